// ===== rtl/mdpc_pkg.sv =====
// Shared constants, codes and types of the multi-DFA path classifier.
`timescale 1ns / 1ps
`default_nettype none
package mdpc_pkg;

   localparam int NUM_TECHNIQUES = 8;
   localparam int NUM_STATES     = 64;
   localparam int NUM_SYMBOLS    = 10;
   localparam int N_AUTO         = NUM_TECHNIQUES + 1;

   localparam int OP_W   = 3;
   localparam int AUTO_W = 4;
   localparam int ST_W   = $clog2(NUM_STATES);
   localparam int SYM_W  = 4;
   localparam int NXT_W  = 7;
   localparam int LIM_W  = 9;
   localparam int TC_W   = 4;
   localparam int MASK_W = 8;
   localparam int CSR_W  = 4;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_LIMIT = 256;
   localparam int TR_DEPTH  = NUM_STATES << SYM_W;
   localparam int TR_AW     = $clog2(TR_DEPTH);

   localparam logic [NXT_W-1:0] STATE_NONE = NXT_W'(NUM_STATES);

   typedef enum logic [OP_W-1:0] {
      OP_WR_TRANS  = 3'd0,
      OP_WR_ACCEPT = 3'd1,
      OP_WR_LIMIT  = 3'd2,
      OP_EVENT     = 3'd3,
      OP_END_PATH  = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE     = 1'd0,
      CSR_TECH_COUNT = 1'd1
   } csr_idx_type;

   // Broadcast from the top level to every automaton lane.
   typedef struct packed {
      logic              clr;
      logic [TR_AW-1:0]  clr_addr;
      logic              ev_go;
      logic              end_go;
      logic              tr_we;
      logic              acc_we;
      logic              lim_we;
      logic [ST_W-1:0]   state_idx;
      logic [SYM_W-1:0]  symbol;
      logic [NXT_W-1:0]  next_state;
      logic              accept_bit;
      logic [LIM_W-1:0]  length_limit;
      logic              bad_seen;
      logic [LIM_W-1:0]  events_seen;
   } lane_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/multi_dfa_path_classifier_core.sv =====
// Top level of the multi-DFA path classifier: request decode, path counters, lanes.
//
//  Channel | Ports                                  | Direction | Handshake
//  req     | req_op .. req_length_limit             | in        | req_valid / req_ready
//  rsp     | rsp_support_mask, rsp_target_accepted  | out       | rsp_valid / rsp_ready
//  csr     | csr_index, csr_wdata                   | in        | csr_we, no wait
//
// One request is accepted per cycle while req_ready is high; an event lookup reads
// each lane's transition RAM, whose read register is forwarded into the next lookup.
// End-of-path results pass a stage register and the output register to rsp_valid.
// After reset a clearing pass over all 1024 addresses fills the transition and accept
// RAMs; req_ready stays low during it. The response side has one stage of slack:
// req_ready drops only when a finished end-of-path result cannot move on.
`timescale 1ns / 1ps
`default_nettype none
module multi_dfa_path_classifier_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [mdpc_pkg::OP_W-1:0]         req_op,
   input  wire logic [mdpc_pkg::AUTO_W-1:0]       req_automaton_index,
   input  wire logic [mdpc_pkg::ST_W-1:0]         req_state_index,
   input  wire logic [mdpc_pkg::SYM_W-1:0]        req_symbol,
   input  wire logic [mdpc_pkg::NXT_W-1:0]        req_next_state,
   input  wire logic                              req_accept_bit,
   input  wire logic [mdpc_pkg::LIM_W-1:0]        req_length_limit,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [mdpc_pkg::MASK_W-1:0]       rsp_support_mask,
   output logic                                   rsp_target_accepted,
   input  wire logic                              csr_we,
   input  wire logic [mdpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mdpc_pkg::CSR_W-1:0]        csr_wdata
);
   import mdpc_pkg::*;

   logic             enable_ff, enable_in;
   logic [TC_W-1:0]  tech_count_ff, tech_count_in;
   logic [TR_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clear_done_ff, clear_done_in;
   logic [LIM_W-1:0] events_ff, events_in;
   logic             bad_ff, bad_in;

   logic             req_fire;
   logic             is_event;
   logic             end_go;
   logic             stall;
   lane_ctrl_type    ctrl;
   logic [N_AUTO-1:0] lane_ok;
   logic [N_AUTO-1:0] lane_acc;

   assign req_ready = clear_done_ff & ~stall;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      ctrl          = '0;
      is_event      = 1'b0;
      ctrl.clr      = ~clear_done_ff;
      ctrl.clr_addr = clr_cnt_ff;
      unique case (op_type'(req_op))
         OP_WR_TRANS:  ctrl.tr_we  = req_fire && (req_symbol < SYM_W'(NUM_SYMBOLS));
         OP_WR_ACCEPT: ctrl.acc_we = req_fire;
         OP_WR_LIMIT:  ctrl.lim_we = req_fire;
         OP_EVENT:     is_event    = req_fire;
         OP_END_PATH:  ctrl.end_go = req_fire;
         default:      ctrl.clr    = ~clear_done_ff;
      endcase
      ctrl.ev_go        = is_event && (req_symbol < SYM_W'(NUM_SYMBOLS));
      ctrl.state_idx    = req_state_index;
      ctrl.symbol       = req_symbol;
      ctrl.next_state   = req_next_state;
      ctrl.accept_bit   = req_accept_bit;
      ctrl.length_limit = req_length_limit;
      ctrl.bad_seen     = bad_ff;
      ctrl.events_seen  = events_ff;
      end_go            = ctrl.end_go;

      events_in = events_ff;
      bad_in    = bad_ff;
      if (end_go) begin
         events_in = '0;
         bad_in    = 1'b0;
      end else if (is_event) begin
         // The count sticks at all ones, above every loadable limit.
         if (events_ff != '1) begin
            events_in = events_ff + 1'b1;
         end
         if (req_symbol >= SYM_W'(NUM_SYMBOLS)) begin
            bad_in = 1'b1;
         end
      end

      clr_cnt_in    = clr_cnt_ff;
      clear_done_in = clear_done_ff;
      if (!clear_done_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == TR_AW'(TR_DEPTH - 1)) begin
            clear_done_in = 1'b1;
         end
      end

      enable_in     = enable_ff;
      tech_count_in = tech_count_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENABLE:     enable_in     = csr_wdata[0];
            CSR_TECH_COUNT: tech_count_in = csr_wdata[TC_W-1:0];
            default:        enable_in     = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         tech_count_ff <= TC_W'(1);
         clr_cnt_ff    <= '0;
         clear_done_ff <= 1'b0;
         events_ff     <= '0;
         bad_ff        <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         tech_count_ff <= tech_count_in;
         clr_cnt_ff    <= clr_cnt_in;
         clear_done_ff <= clear_done_in;
         events_ff     <= events_in;
         bad_ff        <= bad_in;
      end
   end

   for (genvar g = 0; g < N_AUTO; g++) begin : g_lane
      mdpc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sel    (req_automaton_index == AUTO_W'(g)),
         .ok     (lane_ok[g]),
         .acc_rd (lane_acc[g])
      );
   end

   mdpc_result u_result (
      .clock               (clock),
      .reset               (reset),
      .end_go              (end_go),
      .enable              (enable_ff),
      .tech_count          (tech_count_ff),
      .ok                  (lane_ok),
      .acc                 (lane_acc),
      .stall               (stall),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_support_mask    (rsp_support_mask),
      .rsp_target_accepted (rsp_target_accepted)
   );

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      ~clear_done_ff |-> ~req_ready)
      else $error("request taken during memory clearing pass");

   a_path_restart: assert property (@(posedge clock) disable iff (reset)
      end_go |=> (events_ff == '0 && ~bad_ff))
      else $error("path counters not cleared after end of path");

   a_bad_symbol_sticks: assert property (@(posedge clock) disable iff (reset)
      (bad_ff && ~end_go) |=> bad_ff)
      else $error("bad symbol flag dropped inside a path");

endmodule
`default_nettype wire

// ===== rtl/mdpc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mdpc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/mdpc_lane.sv =====
// One automaton: transition and accept memories, current state and path limit.
`timescale 1ns / 1ps
`default_nettype none
module mdpc_lane (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mdpc_pkg::lane_ctrl_type ctrl,
   input  wire logic                  sel,
   output logic                       ok,
   output logic                       acc_rd
);
   import mdpc_pkg::*;

   logic [NXT_W-1:0] state_ff, state_in;
   logic             pend_ff, pend_in;
   logic [LIM_W-1:0] limit_ff, limit_in;
   logic             ok_ff, ok_in;
   logic [ST_W-1:0]  acc_addr_ff, acc_addr_in;

   logic [NXT_W-1:0] tr_rdata;
   logic [NXT_W-1:0] eff_state;
   logic             dead;
   logic             tr_we;
   logic [TR_AW-1:0] tr_waddr;
   logic [NXT_W-1:0] tr_wdata;
   logic [TR_AW-1:0] tr_raddr;
   logic             acc_we;
   logic [ST_W-1:0]  acc_waddr;
   logic             acc_wdata;

   // While a lookup is in flight the state lives in the RAM read register.
   assign eff_state = pend_ff ? tr_rdata : state_ff;
   assign dead      = (eff_state >= STATE_NONE);

   always_comb begin
      tr_we    = ctrl.clr | (ctrl.tr_we & sel);
      tr_waddr = ctrl.clr ? ctrl.clr_addr : {ctrl.state_idx, ctrl.symbol};
      if (ctrl.clr) begin
         tr_wdata = STATE_NONE;
      end else if (ctrl.next_state > STATE_NONE) begin
         tr_wdata = STATE_NONE;
      end else begin
         tr_wdata = ctrl.next_state;
      end
      tr_raddr = {eff_state[ST_W-1:0], ctrl.symbol};

      acc_we    = ctrl.clr | (ctrl.acc_we & sel);
      acc_waddr = ctrl.clr ? ctrl.clr_addr[ST_W-1:0] : ctrl.state_idx;
      acc_wdata = ctrl.clr ? 1'b0 : ctrl.accept_bit;
      acc_addr_in = ctrl.end_go ? eff_state[ST_W-1:0] : acc_addr_ff;

      state_in = ctrl.end_go ? '0 : eff_state;
      pend_in  = ctrl.ev_go & ~dead;

      limit_in = limit_ff;
      if (ctrl.lim_we && sel) begin
         if (ctrl.length_limit > LIM_W'(MAX_LIMIT)) begin
            limit_in = LIM_W'(MAX_LIMIT);
         end else begin
            limit_in = ctrl.length_limit;
         end
      end

      ok_in = ok_ff;
      if (ctrl.end_go) begin
         ok_in = ~ctrl.bad_seen && (limit_ff != '0) &&
                 (ctrl.events_seen <= limit_ff) && ~dead;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         pend_ff  <= 1'b0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         limit_ff <= limit_in;
      end
      ok_ff       <= ok_in;
      acc_addr_ff <= acc_addr_in;
   end

   mdpc_ram #(.WIDTH(NXT_W), .DEPTH(TR_DEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_waddr),
      .wr_data (tr_wdata),
      .rd_addr (tr_raddr),
      .rd_data (tr_rdata)
   );

   mdpc_ram #(.WIDTH(1), .DEPTH(NUM_STATES)) u_accept_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (acc_addr_in),
      .rd_data (acc_rd)
   );

   assign ok = ok_ff;

endmodule
`default_nettype wire

// ===== rtl/mdpc_result.sv =====
// End-of-path result stage: combines accept bits and limit checks into the response.
`timescale 1ns / 1ps
`default_nettype none
module mdpc_result (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              end_go,
   input  wire logic                              enable,
   input  wire logic [mdpc_pkg::TC_W-1:0]         tech_count,
   input  wire logic [mdpc_pkg::N_AUTO-1:0]       ok,
   input  wire logic [mdpc_pkg::N_AUTO-1:0]       acc,
   output logic                                   stall,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [mdpc_pkg::MASK_W-1:0]       rsp_support_mask,
   output logic                                   rsp_target_accepted
);
   import mdpc_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              en_ff, en_in;
   logic [TC_W-1:0]   count_ff, count_in;
   logic              out_valid_ff, out_valid_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              tacc_ff, tacc_in;
   logic              s1_move;

   assign s1_move = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign stall   = s1_valid_ff & ~s1_move;

   always_comb begin
      s1_valid_in  = end_go | (s1_valid_ff & ~s1_move);
      en_in        = end_go ? enable : en_ff;
      count_in     = end_go ? tech_count : count_ff;
      out_valid_in = s1_move | (out_valid_ff & ~rsp_ready);

      tacc_in = en_ff & ok[0] & acc[0];
      mask_in = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < NUM_TECHNIQUES) begin
            mask_in[i] = tacc_in && (i < int'(count_ff)) && ok[i+1] && acc[i+1];
         end
      end
      if (!s1_move) begin
         tacc_in = tacc_ff;
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      en_ff    <= en_in;
      count_ff <= count_in;
      mask_ff  <= mask_in;
      tacc_ff  <= tacc_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_support_mask    = mask_ff;
   assign rsp_target_accepted = tacc_ff;

   a_no_end_while_stalled: assert property (@(posedge clock) disable iff (reset)
      end_go |-> ~stall)
      else $error("end of path request accepted while result stage stalled");

   a_mask_needs_target: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (tacc_ff || mask_ff == '0))
      else $error("technique mask set without target acceptance");

   a_stage_feeds_output: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> out_valid_ff)
      else $error("result lost between stage and output register");

   a_end_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      end_go |=> s1_valid_ff)
      else $error("end of path request did not enter result stage");

endmodule
`default_nettype wire
